@@ rtl/line_rasterizer_unit_defines.svh @@
// Assertion macros for the line rasterizer unit.
// Used by the top level only; relies on clk_i and rst_ni in the including scope.
`ifndef LINE_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define LRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define LRU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define LRU_ASSERT(lbl, prop, msg)
`define LRU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/lru_pkg.sv @@
// Package for the line rasterizer unit: field widths, register indexes,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package lru_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CoordW   = 6;
  localparam int unsigned DimW     = 7;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned AddrW    = 14;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 64;

  // Register reset values.
  localparam logic [DimW-1:0]   FrameWidthRst  = 7'd64;
  localparam logic [DimW-1:0]   FrameHeightRst = 7'd64;
  localparam logic [ColorW-1:0] DrawColorRst   = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgDrawColor   = 2'd2
  } cfg_index_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StSetup = 2'd1,
    StRun   = 2'd2
  } lru_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the endpoints of an accepted command
    logic setup;  // order endpoints and initialise the stepper
    logic step;   // advance to the next pixel
  } lru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic off_frame;  // an endpoint lies outside the frame
    logic last;       // current pixel is the final one of the line
  } lru_status_t;

endpackage

`default_nettype wire

@@ rtl/line_rasterizer_unit.sv @@
// Line rasterizer unit: one line command in, one pixel write beat per pixel out.
// Top level; instantiates lru_cfg, lru_ctrl and lru_dp. Depends on lru_pkg and
// line_rasterizer_unit_defines.svh.
//
// Usage:
//   The slave stream takes one line command per beat (two endpoints). The
//   master stream gives one beat per pixel, tlast marking the final pixel of
//   the line. The configuration port sets frame width, frame height and the
//   draw colour; write it only while no line is in progress.
//   A command accepted in idle passes through the setup state, and its first
//   pixel is presented in the run state that follows. Pixels then follow at one per
//   cycle while the receiver takes them. A command with an endpoint outside
//   the frame yields no beats; setup then returns straight to idle.
//   The rate is set by the quotient and remainder stepper in the datapath,
//   which advances one pixel per step.
//   When the receiver holds tready low the current pixel beat stays on the
//   bus unchanged and no new command is taken until the line is finished.
//   Reset returns the controller to idle and the registers to a 64 by 64
//   frame with an all-ones colour; any line in progress is dropped.
`default_nettype none

`include "line_rasterizer_unit_defines.svh"

module line_rasterizer_unit
  import lru_pkg::*;
#(
  parameter int unsigned MAX_DIM         = 64,
  parameter int unsigned BYTES_PER_PIXEL = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Pixel stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: pixel_x[5:0], pixel_y[11:6], byte_address[25:12],
  //        pixel_color[57:26], zero padding[63:58]
  output logic [OutDataW-1:0] m_axis_tdata,
  // tlast: last_pixel
  output logic                m_axis_tlast,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PadW = OutDataW - (2 * CoordW + AddrW + ColorW);

  logic [DimW-1:0]   width;
  logic [DimW-1:0]   height;
  logic [ColorW-1:0] color;
  lru_cmd_t          cmd;
  lru_status_t       status;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [AddrW-1:0]  byte_address;
  logic              in_beat;
  logic              out_beat;

  // Configuration registers.
  lru_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .width_o     (width),
    .height_o    (height),
    .color_o     (color)
  );

  // Controller.
  lru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  lru_dp #(
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .x_start_i      (s_axis_tdata[5:0]),
    .y_start_i      (s_axis_tdata[11:6]),
    .x_end_i        (s_axis_tdata[17:12]),
    .y_end_i        (s_axis_tdata[23:18]),
    .width_i        (width),
    .height_i       (height),
    .status_o       (status),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .byte_address_o (byte_address)
  );

  // Pack the pixel beat.
  assign m_axis_tdata = {{PadW{1'b0}}, color, byte_address, pixel_y, pixel_x};
  assign m_axis_tlast = status.last;

  // Handshakes on both streams.
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // A line ends on its tlast beat and the bus falls idle straight after.
  `LRU_ASSERT(a_last_ends_line, out_beat && m_axis_tlast |=> !m_axis_tvalid, "beat after tlast")
  // Within a line, pixels follow without gaps.
  `LRU_ASSERT(a_no_gap, out_beat && !m_axis_tlast |=> m_axis_tvalid, "gap inside a line")
  // A newly accepted command goes through setup before any pixel appears.
  `LRU_ASSERT(a_setup_cycle, in_beat |=> !m_axis_tvalid && !s_axis_tready, "no setup cycle")

endmodule

`default_nettype wire

@@ rtl/lru_cfg.sv @@
// Configuration registers of the line rasterizer unit, with frame size clamping.
// Depends on lru_pkg.
`default_nettype none

module lru_cfg
  import lru_pkg::*;
#(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [DimW-1:0]     width_o,
  output logic [DimW-1:0]     height_o,
  output logic [ColorW-1:0]   color_o
);

  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  logic [DimW-1:0]   width_q, width_d;
  logic [DimW-1:0]   height_q, height_d;
  logic [ColorW-1:0] color_q, color_d;

  // Register write decode; unused indexes are ignored.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    color_d  = color_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  width_d  = cfg_data_i[DimW-1:0];
        CfgFrameHeight: height_d = cfg_data_i[DimW-1:0];
        CfgDrawColor:   color_d  = cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
      color_q  <= DrawColorRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      color_q  <= color_d;
    end
  end

  // Sizes above the supported maximum count as the maximum.
  assign width_o  = (width_q > MaxDim) ? MaxDim : width_q;
  assign height_o = (height_q > MaxDim) ? MaxDim : height_q;
  assign color_o  = color_q;

endmodule

`default_nettype wire

@@ rtl/lru_ctrl.sv @@
// Controller of the line rasterizer unit: command acceptance and pixel sequencing.
// Depends on lru_pkg.
`default_nettype none

module lru_ctrl
  import lru_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  lru_status_t status_i,
  output lru_cmd_t    cmd_o
);

  lru_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSetup;
      end
      StSetup: begin
        state_d = status_i.off_frame ? StIdle : StRun;
      end
      StRun: begin
        if (out_ready_i && status_i.last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
      end
      StRun: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/lru_dp.sv @@
// Datapath of the line rasterizer unit: endpoint ordering, exact minor-axis
// stepping by quotient and remainder, and pixel address generation. Depends on lru_pkg.
`default_nettype none

module lru_dp
  import lru_pkg::*;
#(
  parameter int unsigned BYTES_PER_PIXEL = 4
) (
  input  logic              clk_i,
  input  lru_cmd_t          cmd_i,
  input  logic [CoordW-1:0] x_start_i,
  input  logic [CoordW-1:0] y_start_i,
  input  logic [CoordW-1:0] x_end_i,
  input  logic [CoordW-1:0] y_end_i,
  input  logic [DimW-1:0]   width_i,
  input  logic [DimW-1:0]   height_i,
  output lru_status_t       status_o,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [AddrW-1:0]  byte_address_o
);

  localparam int unsigned LinW  = 13;
  localparam int unsigned FullW = 16;

  // Captured endpoints.
  logic [CoordW-1:0] xs_q, ys_q, xe_q, ye_q;

  // Stepper state.
  logic                     steep_q;
  logic [CoordW-1:0]        major_q, major_d;
  logic [CoordW-1:0]        major_end_q;
  logic [CoordW-1:0]        minor_q, minor_d;
  logic [CoordW-1:0]        span_q;
  logic signed [DimW-1:0]   delta_q;
  logic signed [DimW:0]     rem_q, rem_d;

  // Setup signals.
  logic signed [DimW-1:0] dx, dy, delta_s;
  logic [CoordW-1:0]      adx, ady;
  logic                   steep_s;
  logic [CoordW-1:0]      a0, b0, a1, b1;
  logic [CoordW-1:0]      ma0, mb0, ma1, mb1;

  // Step signals.
  logic signed [DimW:0]   rem_sum, span_ext;

  // Address signals.
  logic [LinW-1:0]        lin;
  logic [FullW-1:0]       addr_full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xs_q <= x_start_i;
      ys_q <= y_start_i;
      xe_q <= x_end_i;
      ye_q <= y_end_i;
    end
  end

  // Bounds check against the clamped frame size.
  assign status_o.off_frame = ({1'b0, xs_q} >= width_i) || ({1'b0, xe_q} >= width_i) ||
                              ({1'b0, ys_q} >= height_i) || ({1'b0, ye_q} >= height_i);

  // Pick the major axis, then order the endpoints so the major coordinate rises.
  always_comb begin
    dx      = $signed({1'b0, xe_q}) - $signed({1'b0, xs_q});
    dy      = $signed({1'b0, ye_q}) - $signed({1'b0, ys_q});
    adx     = dx[DimW-1] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady     = dy[DimW-1] ? CoordW'(-dy) : dy[CoordW-1:0];
    steep_s = adx < ady;
    if (steep_s) begin
      a0 = ys_q; b0 = xs_q; a1 = ye_q; b1 = xe_q;
    end else begin
      a0 = xs_q; b0 = ys_q; a1 = xe_q; b1 = ye_q;
    end
    if (a0 > a1) begin
      ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
    end else begin
      ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
    end
    delta_s = $signed({1'b0, mb1}) - $signed({1'b0, mb0});
  end

  // One step of the remainder: the slope never exceeds one, so a single
  // correction keeps the remainder within [0, span).
  always_comb begin
    span_ext = $signed({2'b00, span_q});
    rem_sum  = rem_q + $signed({delta_q[DimW-1], delta_q});
    major_d  = major_q + 1'b1;
    minor_d  = minor_q;
    rem_d    = rem_q;
    if (span_q != '0) begin
      rem_d = rem_sum;
      if (rem_sum >= span_ext) begin
        rem_d   = rem_sum - span_ext;
        minor_d = minor_q + 1'b1;
      end else if (rem_sum < 0) begin
        rem_d   = rem_sum + span_ext;
        minor_d = minor_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      steep_q     <= steep_s;
      major_q     <= ma0;
      major_end_q <= ma1;
      minor_q     <= mb0;
      span_q      <= ma1 - ma0;
      delta_q     <= delta_s;
      rem_q       <= '0;
    end else if (cmd_i.step) begin
      major_q <= major_d;
      minor_q <= minor_d;
      rem_q   <= rem_d;
    end
  end

  assign status_o.last = (major_q == major_end_q);

  // Pixel coordinates and byte address.
  assign pixel_x_o = steep_q ? minor_q : major_q;
  assign pixel_y_o = steep_q ? major_q : minor_q;

  assign lin            = LinW'(pixel_y_o) * LinW'(width_i) + LinW'(pixel_x_o);
  assign addr_full      = FullW'(lin) * FullW'(BYTES_PER_PIXEL);
  assign byte_address_o = addr_full[AddrW-1:0];

endmodule

`default_nettype wire
